// File: hw/rtl/spm_pkg.sv
// Shared types and constants for the stepper ramp position mover.
// Payload structs, controller/datapath handshake structs, codes and coil table.
// No dependencies.
`default_nettype none

package spm_pkg;

    // input item and result item
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] digit;
    } item_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       done_res;
        logic [3:0] position;
        logic [1:0] status;
    } result_t;

    // item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;
    localparam logic [1:0] MODE_SET  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_AT_TGT  = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_BAD_DIG = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_STEPS_PER_POS = 2'd0;
    localparam logic [1:0] CFG_CRUISE_DELAY  = 2'd1;
    localparam logic [1:0] CFG_START_DELAY   = 2'd2;
    localparam logic [1:0] CFG_RAMP_LENGTH   = 2'd3;

    localparam int CFG_WIDTH = 16;

    // configuration reset values
    localparam logic [11:0] SPP_RST    = 12'd200;
    localparam logic [15:0] CRUISE_RST = 16'd2000;
    localparam logic [15:0] START_RST  = 16'd6000;
    localparam logic [9:0]  RAMP_RST   = 10'd40;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic div_start;
        logic finish;
        logic out_load;
    } spm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_step;
        logic div_done;
    } spm_stat_t;

    // two-phase full-step coil pattern
    function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
        logic [3:0] pat;
        unique case (ph)
            2'd0: pat = 4'h3;
            2'd1: pat = 4'h6;
            2'd2: pat = 4'hC;
            2'd3: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spm_div.sv
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 10-bit divisor.
// Depends on nothing outside itself.
`default_nettype none

module spm_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [9:0]  divisor,
    output logic             done,
    output logic [31:0]      quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [9:0]  rem_reg, rem_next;
    logic [9:0]  dsr_reg, dsr_next;
    logic [10:0] trial;
    logic [10:0] trial_sub;

    assign trial     = {rem_reg, quo_reg[31]};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial_sub[9:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[9:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// File: hw/rtl/spm_dp.sv
// Datapath: configuration registers, mover state, ramp multiply and divide,
// result register. Uses spm_pkg and spm_div; driven by spm_ctrl commands.
`default_nettype none

module spm_dp
    import spm_pkg::*;
#(
    parameter int POSITIONS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data,
    input  wire item_t                item,
    input  wire spm_cmd_t             cmd,
    output spm_stat_t                 stat,
    output result_t                   result
);

    localparam logic [4:0] POS_N = 5'(POSITIONS);

    // configuration
    logic [11:0] spp_reg, spp_next;
    logic [15:0] cruise_reg, cruise_next;
    logic [15:0] start_reg, start_next;
    logic [9:0]  ramp_reg, ramp_next;

    // mover state
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  cur_reg, cur_next;
    logic [3:0]  target_reg, target_next;
    logic [15:0] step_reg, step_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] delay_reg, delay_next;
    logic [9:0]  rused_reg, rused_next;
    logic        moving_reg, moving_next;
    logic [3:0]  coil_reg, coil_next;
    logic [1:0]  status_reg, status_next;
    logic        done_reg, done_next;

    // per-item payload
    item_t       item_reg, item_next;
    logic [15:0] factor_reg, factor_next;
    logic        cruise_sel_reg, cruise_sel_next;
    logic [31:0] prod_reg, prod_next;
    result_t     result_reg, result_next;

    // derived values
    logic        digit_ok;
    logic [4:0]  dist_sum;
    logic [4:0]  fwd_dist;
    logic [15:0] tot_new;
    logic [14:0] half_new;
    logic [9:0]  rnew;
    logic [15:0] dl_dec;
    logic [15:0] sn_inc;
    logic        sn_last;
    logic [1:0]  phase_dec;
    logic [16:0] decel_edge;
    logic        tick_cruise;
    logic [15:0] tick_factor;
    logic [15:0] diff;
    logic [15:0] d_raw;
    logic [15:0] d_fix;
    logic        div_done;
    logic [31:0] quot;

    assign digit_ok = {1'b0, item_reg.digit} < POS_N;
    assign dist_sum = {1'b0, item_reg.digit} + POS_N - {1'b0, cur_reg};
    assign fwd_dist = (dist_sum >= POS_N) ? (dist_sum - POS_N) : dist_sum;
    assign tot_new  = {12'd0, fwd_dist[3:0]} * {4'd0, spp_reg};
    assign half_new = tot_new[15:1];

    always_comb
    begin
        if ({5'd0, ramp_reg} < half_new)
            rnew = ramp_reg;
        else
            rnew = half_new[9:0];
        if (rnew == 10'd0)
            rnew = 10'd1;
    end

    assign dl_dec    = (delay_reg != 16'd0) ? (delay_reg - 16'd1) : delay_reg;
    assign sn_inc    = step_reg + 16'd1;
    assign sn_last   = sn_inc >= total_reg;
    assign phase_dec = phase_reg - 2'd1;

    // deceleration starts at total - r; a negative edge never matches
    assign decel_edge = {1'b0, total_reg} - {7'd0, rused_reg};

    always_comb
    begin
        tick_cruise = 1'b0;
        tick_factor = sn_inc;
        if (sn_inc < {6'd0, rused_reg})
            tick_factor = sn_inc;
        else if (!decel_edge[16] && (sn_inc >= decel_edge[15:0]))
            tick_factor = total_reg - sn_inc;
        else
            tick_cruise = 1'b1;
    end

    assign diff  = (start_reg > cruise_reg) ? (start_reg - cruise_reg) : 16'd0;
    assign d_raw = cruise_sel_reg ? cruise_reg : (start_reg - quot[15:0]);
    assign d_fix = (d_raw == 16'd0) ? 16'd1 : d_raw;

    spm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (rused_reg),
        .done     (div_done),
        .quot     (quot)
    );

    always_comb
    begin
        stat.div_done  = div_done;
        stat.need_step = 1'b0;
        if (item_reg.mode == MODE_TICK)
            stat.need_step = moving_reg && (dl_dec == 16'd0) && !sn_last;
        else if (item_reg.mode == MODE_MOVE)
            stat.need_step = !moving_reg && digit_ok && (fwd_dist != 5'd0)
                             && (tot_new != 16'd0);
    end

    always_comb
    begin
        spp_next        = spp_reg;
        cruise_next     = cruise_reg;
        start_next      = start_reg;
        ramp_next       = ramp_reg;
        phase_next      = phase_reg;
        cur_next        = cur_reg;
        target_next     = target_reg;
        step_next       = step_reg;
        total_next      = total_reg;
        delay_next      = delay_reg;
        rused_next      = rused_reg;
        moving_next     = moving_reg;
        coil_next       = coil_reg;
        status_next     = status_reg;
        done_next       = done_reg;
        item_next       = item_reg;
        factor_next     = factor_reg;
        cruise_sel_next = cruise_sel_reg;
        prod_next       = prod_reg;
        result_next     = result_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEPS_PER_POS: spp_next    = cfg_data[11:0];
                CFG_CRUISE_DELAY:  cruise_next = cfg_data[15:0];
                CFG_START_DELAY:   start_next  = cfg_data[15:0];
                CFG_RAMP_LENGTH:   ramp_next   = cfg_data[9:0];
            endcase
        end

        if (cmd.load)
            item_next = item;

        if (cmd.eval)
        begin
            status_next = ST_OK;
            done_next   = 1'b0;
            unique case (item_reg.mode)
                MODE_TICK:
                begin
                    if (moving_reg)
                    begin
                        delay_next = dl_dec;
                        if (dl_dec == 16'd0)
                        begin
                            step_next = sn_inc;
                            if (sn_last)
                            begin
                                coil_next   = 4'd0;
                                cur_next    = target_reg;
                                moving_next = 1'b0;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                phase_next      = phase_dec;
                                coil_next       = coil_pattern(phase_dec);
                                factor_next     = tick_factor;
                                cruise_sel_next = tick_cruise;
                            end
                        end
                    end
                end
                MODE_MOVE, MODE_SET:
                begin
                    if (moving_reg)
                        status_next = ST_BUSY;
                    else if (!digit_ok)
                        status_next = ST_BAD_DIG;
                    else if (item_reg.mode == MODE_SET)
                        cur_next = item_reg.digit;
                    else if (fwd_dist == 5'd0)
                        status_next = ST_AT_TGT;
                    else
                    begin
                        target_next = item_reg.digit;
                        total_next  = tot_new;
                        rused_next  = rnew;
                        step_next   = 16'd0;
                        if (tot_new == 16'd0)
                        begin
                            coil_next = 4'd0;
                            cur_next  = item_reg.digit;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            // first step is always on the acceleration side, s = 0
                            moving_next     = 1'b1;
                            phase_next      = phase_dec;
                            coil_next       = coil_pattern(phase_dec);
                            factor_next     = 16'd0;
                            cruise_sel_next = 1'b0;
                        end
                    end
                end
                MODE_NONE:
                begin
                end
            endcase
        end

        if (cmd.mul)
            prod_next = diff * factor_reg;

        if (cmd.finish)
            delay_next = d_fix;

        if (cmd.out_load)
        begin
            result_next.coils    = coil_reg;
            result_next.busy_res = moving_reg;
            result_next.done_res = done_reg;
            result_next.position = cur_reg;
            result_next.status   = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg    <= SPP_RST;
            cruise_reg <= CRUISE_RST;
            start_reg  <= START_RST;
            ramp_reg   <= RAMP_RST;
            phase_reg  <= '0;
            cur_reg    <= '0;
            target_reg <= '0;
            step_reg   <= '0;
            total_reg  <= '0;
            delay_reg  <= '0;
            rused_reg  <= 10'd1;
            moving_reg <= 1'b0;
            coil_reg   <= '0;
            status_reg <= ST_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            spp_reg    <= spp_next;
            cruise_reg <= cruise_next;
            start_reg  <= start_next;
            ramp_reg   <= ramp_next;
            phase_reg  <= phase_next;
            cur_reg    <= cur_next;
            target_reg <= target_next;
            step_reg   <= step_next;
            total_reg  <= total_next;
            delay_reg  <= delay_next;
            rused_reg  <= rused_next;
            moving_reg <= moving_next;
            coil_reg   <= coil_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        factor_reg     <= factor_next;
        cruise_sel_reg <= cruise_sel_next;
        prod_reg       <= prod_next;
        result_reg     <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/spm_ctrl.sv
// Controller: sequences one item at a time through evaluate, ramp multiply,
// divide (only when a step begins) and result load. Uses spm_pkg; commands spm_dp.
`default_nettype none

module spm_ctrl
    import spm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    output logic           result_valid,
    input  wire logic      result_ready,
    input  wire spm_stat_t stat,
    output spm_cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_MUL    = 6'b000100,
        S_DSTART = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rvalid_reg, rvalid_next;
    logic   out_free;

    assign item_ready = (state_reg == S_IDLE);
    assign out_free   = !rvalid_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.load      = item_valid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.need_step ? S_MUL : S_OUT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the result register to be free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (cmd.out_load)
            rvalid_next = 1'b1;
        else if (result_ready)
            rvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign result_valid = rvalid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stepper_ramp_position_mover.sv
// Sequencing: a tick that starts no new step, a set or a rejected command goes from
// evaluate straight to result load; an item that begins a step first passes through
// a 16x16 multiply and then the bit-serial ramp divider before its result is loaded.
// One item at a time: the next is taken the cycle after the result is registered;
// the result load itself waits until the result register is free.
// Reset (rst_n, async, active low): coils off, position 0, idle, registers at defaults.
`default_nettype none

module stepper_ramp_position_mover
    import spm_pkg::*;
#(
    parameter int POSITIONS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire item_t                item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output result_t                   result
);

    spm_cmd_t  cmd;
    spm_stat_t stat;

    spm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    spm_dp #(
        .POSITIONS (POSITIONS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: test/spm_move_checker.sv
// Watches both item channels and the register port of the stepper ramp position mover,
// predicts every result item and compares it field by field.
// Depends on spm_pkg for the payload structs, modes, status codes and register indexes.

module spm_move_checker
    import spm_pkg::*;
#(
    parameter int POSITIONS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  item_t                item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result,
    output int                   error_count,
    output int                   pending_count
);

    // register copies
    logic [11:0] cfg_spp;
    logic [15:0] cfg_cruise;
    logic [15:0] cfg_start;
    logic [9:0]  cfg_ramp;

    // mover state
    logic [1:0]  mv_phase;
    logic [3:0]  cur_pos;
    logic [3:0]  tgt_pos;
    logic [15:0] step_num;
    logic [15:0] step_cnt;
    logic [15:0] hold_left;
    logic [9:0]  ramp_span;
    logic        in_motion;
    logic [3:0]  coil_q;

    result_t expected_results[$];

    // ticks to hold step s: ramp up over the first steps, down over the last ones
    function automatic logic [15:0] step_hold_ticks(input logic [15:0] s);
        logic [31:0] r;
        logic [31:0] diff;
        logic [31:0] tot;
        logic [31:0] rem;
        logic [31:0] d;
        r = {22'd0, ramp_span};
        if (r == 0)
            r = 1;
        // start below cruise: no ramp at all
        diff = (cfg_start > cfg_cruise) ? {16'd0, cfg_start - cfg_cruise} : 32'd0;
        tot = {16'd0, step_cnt};
        if ({16'd0, s} < r)
            d = {16'd0, cfg_start} - (diff * {16'd0, s}) / r;
        else if ({16'd0, s} >= tot - r)
        begin
            rem = (tot > {16'd0, s}) ? tot - {16'd0, s} : 32'd1;
            d = {16'd0, cfg_start} - (diff * rem) / r;
        end
        else
            d = {16'd0, cfg_cruise};
        if (d == 0)
            d = 1;
        return d[15:0];
    endfunction

    task automatic start_next_step();
        mv_phase = mv_phase + 2'd3;
        case (mv_phase)
            2'd0: coil_q = 4'h3;
            2'd1: coil_q = 4'h6;
            2'd2: coil_q = 4'hC;
            default: coil_q = 4'h9;
        endcase
        hold_left = step_hold_ticks(step_num);
    endtask

    task automatic predict_item(input item_t it, output result_t r);
        logic [1:0]  st;
        logic        done;
        int          fwd_dist;
        logic [15:0] half;
        st = ST_OK;
        done = 1'b0;
        case (it.mode)
            MODE_TICK:
            begin
                if (in_motion)
                begin
                    if (hold_left > 0)
                        hold_left = hold_left - 1'b1;
                    if (hold_left == 0)
                    begin
                        step_num = step_num + 1'b1;
                        if (step_num >= step_cnt)
                        begin
                            coil_q = 4'h0;
                            cur_pos = tgt_pos;
                            in_motion = 1'b0;
                            done = 1'b1;
                        end
                        else
                            start_next_step();
                    end
                end
            end
            MODE_MOVE, MODE_SET:
            begin
                // busy wins over a bad digit
                if (in_motion)
                    st = ST_BUSY;
                else if (it.digit >= POSITIONS)
                    st = ST_BAD_DIG;
                else if (it.mode == MODE_SET)
                    cur_pos = it.digit;
                else
                begin
                    fwd_dist = (int'(it.digit) + POSITIONS - int'(cur_pos)) % POSITIONS;
                    if (fwd_dist == 0)
                        st = ST_AT_TGT;
                    else
                    begin
                        tgt_pos = it.digit;
                        step_cnt = 16'(fwd_dist * int'(cfg_spp));
                        half = step_cnt / 2;
                        ramp_span = ({6'd0, cfg_ramp} < half) ? cfg_ramp : half[9:0];
                        if (ramp_span == 0)
                            ramp_span = 10'd1;
                        step_num = 16'd0;
                        // no steps per position: the move lands at once
                        if (step_cnt == 0)
                        begin
                            coil_q = 4'h0;
                            cur_pos = tgt_pos;
                            done = 1'b1;
                        end
                        else
                        begin
                            in_motion = 1'b1;
                            start_next_step();
                        end
                    end
                end
            end
            default: ;
        endcase
        r.coils    = coil_q;
        r.busy_res = in_motion;
        r.done_res = done;
        r.position = cur_pos;
        r.status   = st;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t predicted;
        result_t wanted;
        if (!rst_n)
        begin
            cfg_spp = SPP_RST;
            cfg_cruise = CRUISE_RST;
            cfg_start = START_RST;
            cfg_ramp = RAMP_RST;
            mv_phase = 2'd0;
            cur_pos = 4'd0;
            tgt_pos = 4'd0;
            step_num = 16'd0;
            step_cnt = 16'd0;
            hold_left = 16'd0;
            ramp_span = 10'd1;
            in_motion = 1'b0;
            coil_q = 4'h0;
            expected_results.delete();
            error_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEPS_PER_POS: cfg_spp = cfg_data[11:0];
                    CFG_CRUISE_DELAY:  cfg_cruise = cfg_data[15:0];
                    CFG_START_DELAY:   cfg_start = cfg_data[15:0];
                    default:           cfg_ramp = cfg_data[9:0];
                endcase
            end
            if (item_valid && item_ready)
            begin
                predict_item(item, predicted);
                expected_results.push_back(predicted);
            end
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no item waiting for it");
                    error_count++;
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    if (result.coils !== wanted.coils)
                    begin
                        $error("coils: expected %0h, actual %0h", wanted.coils, result.coils);
                        error_count++;
                    end
                    if (result.busy_res !== wanted.busy_res)
                    begin
                        $error("busy_res: expected %0d, actual %0d",
                               wanted.busy_res, result.busy_res);
                        error_count++;
                    end
                    if (result.done_res !== wanted.done_res)
                    begin
                        $error("done_res: expected %0d, actual %0d",
                               wanted.done_res, result.done_res);
                        error_count++;
                    end
                    if (result.position !== wanted.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               wanted.position, result.position);
                        error_count++;
                    end
                    if (result.status !== wanted.status)
                    begin
                        $error("status: expected %0d, actual %0d", wanted.status, result.status);
                        error_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// File: test/stepper_ramp_position_mover_tb.sv
// Top of the stepper ramp position mover testbench: clock, reset, register writes,
// item stimulus with bursts and receiver stalls, and the verdict.
// Depends on spm_pkg, the block itself and spm_move_checker.

module stepper_ramp_position_mover_tb;
    import spm_pkg::*;

    localparam int POSITIONS     = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 48;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 110;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = 2'd0;
    logic [CFG_WIDTH-1:0] cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;

    int   error_count;
    int   pending_count;
    int   burst_left = 0;
    int   items_sent = 0;
    int   holds_asked = 0;
    int   holds_done = 0;
    logic last_busy = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stepper_ramp_position_mover #(.POSITIONS(POSITIONS)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    spm_move_checker #(.POSITIONS(POSITIONS)) u_move_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            last_busy <= result.busy_res;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("stepper_ramp_position_mover test failed");
        $finish;
    end

    // receiver: segments of steady, light or heavy stalling, plus long hold-offs on request
    initial
    begin
        int seg_len;
        int seg_kind;
        forever
        begin
            seg_len = $urandom_range(4, 40);
            seg_kind = $urandom_range(0, 3);
            repeat (seg_len)
            begin
                @(negedge clk);
                if (holds_done < holds_asked)
                begin
                    result_ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                    holds_done++;
                end
                else
                begin
                    case (seg_kind)
                        0, 1: result_ready <= 1'b1;
                        2: result_ready <= ($urandom_range(0, 9) < 7);
                        default: result_ready <= ($urandom_range(0, 9) < 3);
                    endcase
                end
            end
        end
    end

    // offer one item; returns at the edge that accepted it
    task automatic push_item(input logic [1:0] mode, input logic [3:0] digit);
        int    gap;
        item_t nxt;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        nxt.mode = mode;
        nxt.digit = digit;
        item_valid <= 1'b1;
        item <= nxt;
        items_sent++;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic wait_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_regs(input logic [11:0] spp, input logic [15:0] cruise,
                              input logic [15:0] start, input logic [9:0] ramp);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STEPS_PER_POS;
        cfg_data <= {4'd0, spp};
        @(negedge clk);
        cfg_index <= CFG_CRUISE_DELAY;
        cfg_data <= cruise;
        @(negedge clk);
        cfg_index <= CFG_START_DELAY;
        cfg_data <= start;
        @(negedge clk);
        cfg_index <= CFG_RAMP_LENGTH;
        cfg_data <= {6'd0, ramp};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_noise();
        push_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    endtask

    // tick in batches, with the odd stray command, until the move is over
    task automatic finish_move();
        int batch;
        do
        begin
            batch = $urandom_range(1, 10);
            repeat (batch)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_item(2'($urandom_range(1, 3)), 4'($urandom_range(0, 15)));
                else
                    push_item(MODE_TICK, 4'($urandom_range(0, 15)));
            end
            wait_results();
        end
        while (last_busy);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [11:0] spp;
        logic [15:0] cruise;
        logic [15:0] start;
        logic [9:0]  ramp;
        int          phase_end;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: nothing here may start a move
        push_item(MODE_TICK, 4'd0);
        push_item(MODE_NONE, 4'd15);
        push_item(MODE_MOVE, 4'd0);
        push_item(MODE_MOVE, 4'd10);
        push_item(MODE_SET, 4'd15);
        push_item(MODE_SET, 4'd9);
        push_item(MODE_MOVE, 4'd9);
        push_item(MODE_SET, 4'd0);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        // zero steps per position: moves land at once
        write_regs(12'd0, 16'd1, 16'd1, 10'd0);
        push_item(MODE_MOVE, 4'd5);
        push_item(MODE_MOVE, 4'd4);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        // short ramp, with commands refused while moving
        write_regs(12'd1, 16'd2, 16'd5, 10'd2);
        push_item(MODE_MOVE, 4'd2);
        push_item(MODE_MOVE, 4'd7);
        push_item(MODE_SET, 4'd1);
        push_item(MODE_SET, 4'd12);
        finish_move();

        // zero delays are held for one tick
        write_regs(12'd2, 16'd0, 16'd0, 10'd1023);
        push_item(MODE_MOVE, 4'd3);
        finish_move();

        // start below cruise
        write_regs(12'd4, 16'd65535, 16'd1, 10'd1023);
        push_item(MODE_MOVE, 4'd4);
        finish_move();

        for (int ph = 0; ph < 5; ph++)
        begin
            spp = ($urandom_range(0, 15) == 0) ? 12'd0 : 12'($urandom_range(1, 3));
            cruise = 16'($urandom_range(1, 4));
            start = 16'($urandom_range(1, 7));
            ramp = ($urandom_range(0, 3) == 0) ? 10'd1023 : 10'($urandom_range(0, 4));
            write_regs(spp, cruise, start, ramp);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_item(MODE_SET, 4'($urandom_range(0, POSITIONS - 1)));
                    if ($urandom_range(0, 9) == 0)
                        push_item(MODE_MOVE, 4'($urandom_range(0, 15)));
                    else
                        push_item(MODE_MOVE, 4'($urandom_range(0, POSITIONS - 1)));
                    // once in a while let the receiver sit out a long stretch
                    if ((ph == 1 || ph == 3) && holds_asked < ph)
                    begin
                        holds_asked++;
                        burst_left = 40;
                    end
                    finish_move();
                end
                else
                    push_noise();
            end
            finish_move();
        end

        // largest settings: the move cannot finish within the run, only its start is seen
        write_regs(12'd4095, 16'd65535, 16'd65535, 10'd1023);
        push_item(MODE_SET, 4'd5);
        push_item(MODE_MOVE, 4'd4);
        repeat (20) push_item(MODE_TICK, 4'd0);
        push_item(MODE_MOVE, 4'd1);
        push_item(MODE_SET, 4'd2);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("stepper_ramp_position_mover test passed");
        else
            $display("stepper_ramp_position_mover test failed");
        $finish;
    end

endmodule
